// File: sv/is_pkg.sv
// Shared types and constants for the insertion sorter.
`timescale 1ns / 1ps
`default_nettype none
package is_pkg;
	localparam int VALUE_W     = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} item_t;
endpackage
`default_nettype wire

// File: sv/is_if.sv
// Valid/ready channel interfaces for input items and sorted results.
`timescale 1ns / 1ps
`default_nettype none
interface is_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               last;

	modport source (output valid, value, last, input ready);
	modport sink   (input valid, value, last, output ready);
endinterface

interface is_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value_res;
	logic               last_res;
	logic               overflow;

	modport source (output valid, value_res, last_res, overflow, input ready);
	modport sink   (input valid, value_res, last_res, overflow, output ready);
endinterface
`default_nettype wire

// File: sv/is_queue.sv
// Front end: accepts input transactions into a short FIFO ahead of the sorting row.
`timescale 1ns / 1ps
`default_nettype none
module is_queue
	import is_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	is_in_if.sink      in_ch,
	output item_t      item,
	output logic       item_valid,
	input  wire logic  item_ready
);
	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign in_ch.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign item_valid  = (cnt_q != '0);
	assign item        = mem_q[rd_ptr_q];
	assign push        = in_ch.valid && in_ch.ready;
	assign pop         = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{value: in_ch.value, last: in_ch.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/is_cells.sv
// Back end: row of compare-and-shift cells that inserts items and drains the sorted set.
`timescale 1ns / 1ps
`default_nettype none
module is_cells
	import is_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t item,
	input  wire logic  item_valid,
	output logic       item_ready,
	is_out_if.source   out_ch
);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic signed [VALUE_W-1:0] data_q [CAPACITY];
	logic signed [VALUE_W-1:0] ins_d  [CAPACITY];
	logic [CAPACITY-1:0]       gt;
	logic [CNT_W-1:0]          count_q;
	logic                      drain_q;
	logic                      dropped_q;
	logic                      pop;
	logic                      full;
	logic                      fire;

	assign item_ready = !drain_q;
	assign pop        = item_valid && !drain_q;
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign fire       = out_ch.valid && out_ch.ready;

	// each cell flags an occupied entry greater than the incoming value
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign gt[i] = (CNT_W'(i) < count_q) && (data_q[i] > item.value);
		if (i == 0) begin : g_first
			assign ins_d[i] = (gt[i] || count_q == '0) ? item.value : data_q[i];
		end else begin : g_rest
			assign ins_d[i] = gt[i-1] ? data_q[i-1]
			                : (gt[i] || CNT_W'(i) == count_q) ? item.value : data_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !full) begin
			data_q <= ins_d;
		end else if (fire) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				data_q[i] <= data_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			drain_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else if (pop) begin
			if (!full) begin
				count_q <= count_q + 1'b1;
			end else begin
				dropped_q <= 1'b1;
			end
			if (item.last) begin
				drain_q <= 1'b1;
			end
		end else if (fire) begin
			count_q <= count_q - 1'b1;
			if (count_q == CNT_W'(1)) begin
				drain_q   <= 1'b0;
				dropped_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid     = drain_q;
	assign out_ch.value_res = data_q[0];
	assign out_ch.last_res  = (count_q == CNT_W'(1));
	assign out_ch.overflow  = dropped_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> count_q != '0)
		else $error("draining an empty row");
	a_set_done: assert property (@(posedge clk) disable iff (!arst_n)
		fire && out_ch.last_res |=> count_q == '0 && !dropped_q && !drain_q)
		else $error("row not empty after final result");
	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !out_ch.last_res |=> $past(data_q[0]) <= data_q[0])
		else $error("results out of order");
endmodule
`default_nettype wire

// File: sv/insertion_sorter.sv
// Insertion sorter top level: input FIFO feeding a compare-and-shift sorting row.
// A transaction flagged last is registered in the FIFO, then sets the row's drain flag, which offers the first result.
// One item per cycle while a set streams in and the FIFO has room; a set of N results drains in N output transfers.
// While a set drains the row takes no items; the four-entry FIFO keeps accepting until it is full.
// Reset (arst_n low, asynchronous) empties the FIFO and the row and clears the overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module insertion_sorter
	import is_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	is_in_if.sink    in_ch,
	is_out_if.source out_ch
);
	// queue to row transaction
	item_t item;
	logic  item_valid;
	logic  item_ready;

	// front: buffers incoming transactions so the input can go on during a drain until the FIFO fills
	is_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready)
	);

	// back: inserts one value per cycle while not draining, in sorted order; strictly larger entries shift up,
	// so equal values keep arrival order; values past CAPACITY are dropped and flagged;
	// a last-flagged item starts the drain, lowest entry first, straight from cell zero
	is_cells #(
		.CAPACITY (CAPACITY)
	) u_cells (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.out_ch     (out_ch)
	);
endmodule
`default_nettype wire

// File: tb/tb_insertion_sorter.sv
// Self-checking testbench for the insertion sorter: set streams, overflow sets, idle phases.
`timescale 1ns / 1ps
module tb_insertion_sorter;
	import is_pkg::*;

	localparam int CAP        = 32;
	// Cycles without any transaction before the run is declared hung.
	localparam int HANG_LIMIT = 4000;
	// Quiet cycles after the last expected result, enough for a full drain.
	localparam int TAIL_WAIT  = CAP + 16;

	logic clk;
	logic arst_n;

	is_in_if  in_ch ();
	is_out_if out_ch ();

	insertion_sorter #(
		.CAPACITY(CAP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	// Tracks the set being collected and the sorted results still owed by the block.
	class sort_scoreboard;
		typedef struct {
			logic signed [VALUE_W-1:0] value;
			logic                      last;
			logic                      overflow;
		} sorted_entry_t;

		logic signed [VALUE_W-1:0] set_store [CAP];
		int                        set_fill;
		bit                        set_dropped;
		sorted_entry_t             owed [$];
		int                        errors;

		function new();
			set_fill    = 0;
			set_dropped = 0;
			errors      = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("%0t ns mismatch: %s", $time, msg);
			errors++;
		endtask

		// Insert behind every entry that is not larger; a full store drops the item.
		function void note_item(input item_t it);
			int            pos;
			sorted_entry_t e;
			if (set_fill < CAP) begin
				pos = set_fill;
				while (pos > 0 && set_store[pos-1] > it.value) begin
					set_store[pos] = set_store[pos-1];
					pos--;
				end
				set_store[pos] = it.value;
				set_fill++;
			end else begin
				set_dropped = 1;
			end
			if (it.last) begin
				for (int i = 0; i < set_fill; i++) begin
					e.value    = set_store[i];
					e.last     = (i == set_fill - 1);
					e.overflow = set_dropped;
					owed       = {owed, e};
				end
				set_fill    = 0;
				set_dropped = 0;
			end
		endfunction

		task check_result(input logic signed [VALUE_W-1:0] value, input logic last,
				input logic overflow);
			sorted_entry_t e;
			if (owed.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%0d last=%b ovf=%b",
					value, last, overflow));
			end else begin
				e = owed.pop_front();
				if (value !== e.value || last !== e.last || overflow !== e.overflow)
					report_mismatch($sformatf(
						"got value=%0d last=%b ovf=%b, want value=%0d last=%b ovf=%b",
						value, last, overflow, e.value, e.last, e.overflow));
			end
		endtask
	endclass

	sort_scoreboard sb;

	int sender_idle_pct;
	int receiver_stall_pct;
	int items_sent;
	int hang_count = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Monitors: a transaction counts at an edge where valid and ready were both high.
	always @(posedge clk) begin
		item_t it;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			it.value = in_ch.value;
			it.last  = in_ch.last;
			sb.note_item(it);
		end
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.value_res, out_ch.last_res, out_ch.overflow);
	end

	// Result side back-pressure, re-rolled every cycle.
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Hang detector: any transaction on either channel restarts the count.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			hang_count <= 0;
		end else begin
			hang_count <= hang_count + 1;
			if (hang_count >= HANG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Mix of extremes, a narrow band around zero for duplicates, and full-width noise.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		logic signed [VALUE_W-1:0] v;
		case ($urandom_range(9))
			0:       v = {1'b1, {(VALUE_W-1){1'b0}}};
			1:       v = {1'b0, {(VALUE_W-1){1'b1}}};
			2, 3:    v = int'($urandom_range(6)) - 3;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Called right after a rising edge; returns right after the accepting edge.
	task send_item(input logic signed [VALUE_W-1:0] value, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= value;
		in_ch.last  <= last;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	task send_set(input int size);
		for (int i = 0; i < size; i++)
			send_item(pick_value(), i == size - 1);
	endtask

	// Sender holds off until every owed result has been seen.
	task wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.owed.size() != 0);
	endtask

	// Random sets: mostly short, some long, a few that spill past capacity.
	task send_random_sets(input int item_budget);
		int start;
		int r;
		int size;
		start = items_sent;
		while (items_sent - start < item_budget) begin
			r = $urandom_range(99);
			if (r < 50)
				size = $urandom_range(6, 1);
			else if (r < 80)
				size = $urandom_range(20, 7);
			else if (r < 92)
				size = $urandom_range(CAP, 21);
			else
				size = $urandom_range(CAP + 8, CAP + 1);
			send_set(size);
		end
	endtask

	initial begin
		sb                 = new();
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.value        = '0;
		in_ch.last         = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		items_sent         = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single-element sets at both extremes.
		send_item({1'b0, {(VALUE_W-1){1'b1}}}, 1'b1);
		send_item({1'b1, {(VALUE_W-1){1'b0}}}, 1'b1);
		// Extremes, sign boundary and duplicates in one set.
		send_item(0, 1'b0);
		send_item(-1, 1'b0);
		send_item(1, 1'b0);
		send_item({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
		send_item({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
		send_item(5, 1'b0);
		send_item(5, 1'b0);
		send_item(-5, 1'b0);
		send_item(0, 1'b1);
		// Descending input: every insert shifts the whole row.
		for (int i = 4; i >= 0; i--)
			send_item(i * 1000 - 2000, i == 0);
		// Ascending input: no shifting at all.
		for (int i = 0; i < 5; i++)
			send_item(i * 1000 - 2000, i == 4);
		wait_drained();

		// Phase 1: no idling; exactly full set, then one whose last item is dropped.
		send_set(CAP);
		send_set(CAP + 5);
		send_random_sets(75);
		wait_drained();

		// Phase 2: sender gaps.
		sender_idle_pct    = 61;
		receiver_stall_pct = 0;
		send_random_sets(75);
		wait_drained();

		// Phase 3: receiver stalls; overflow by a single item.
		sender_idle_pct    = 0;
		receiver_stall_pct = 61;
		send_set(CAP + 1);
		send_random_sets(75);
		wait_drained();

		// Phase 4: light idling on both sides.
		sender_idle_pct    = 11;
		receiver_stall_pct = 11;
		send_random_sets(75);
		wait_drained();

		repeat (TAIL_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
